>>> rtl/core/encoded_polyline_decoder_top_macros.svh
// Assertion macros for the encoded polyline decoder.
// Depends on a clock named clk and an active-low reset named rst_n in the using module.
`ifndef ENCODED_POLYLINE_DECODER_TOP_MACROS_SVH
`define ENCODED_POLYLINE_DECODER_TOP_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define EPD_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Antecedent implies consequent in the next cycle.
`define EPD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

// Condition never holds.
`define EPD_ASSERT_NEVER(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("assertion failed");

`endif

>>> rtl/core/epd_pkg.sv
// Package for the encoded polyline decoder: constants, state and result types,
// and the chunk shift helper. No dependencies.
`default_nettype none

package epd_pkg;

    localparam int COORD_W     = 32;
    localparam int CHUNK_W     = 5;
    localparam int CNT_W       = 3;
    localparam int SHIFT_W     = 5;

    localparam logic [7:0]       CHAR_BIAS   = 8'd63;
    localparam logic [7:0]       CHAR_MAX    = 8'd126;
    localparam logic [7:0]       CHAR_CONT   = 8'd95;
    localparam logic [CNT_W-1:0] CHUNK_LIMIT = 3'd7;

    typedef struct packed {
        logic [COORD_W-1:0] accum;
        logic [CNT_W-1:0]   cnt;
        logic               on_lon;
        logic [COORD_W-1:0] lat;
        logic [COORD_W-1:0] lon;
        logic               perr;
    } epd_state_t;

    typedef struct packed {
        logic               emit;
        logic [COORD_W-1:0] lat;
        logic [COORD_W-1:0] lon;
        logic               bad;
    } epd_result_t;

    // Bit position of chunk number cnt: 5 * cnt, at most 30 for the cnt values below CHUNK_LIMIT.
    function automatic logic [SHIFT_W-1:0] chunk_shift(input logic [CNT_W-1:0] cnt);
        logic [SHIFT_W-1:0] c;
        c = {{(SHIFT_W-CNT_W){1'b0}}, cnt};
        return (c << 2) + c;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/encoded_polyline_decoder_top.sv
// Encoded polyline decoder top level: input register, decode step, result register.
// Depends on epd_pkg, epd_step and encoded_polyline_decoder_top_macros.svh.
//
//   channel | signals                                     | direction
//   --------+---------------------------------------------+----------
//   in      | in_valid, in_stall, char_code, restart      | toward block
//   out     | out_valid, out_stall, latitude_e5,          | from block
//           | longitude_e5, bad_input                     |
//
// One character per cycle while in_stall is low; the input register takes a character, and
// the result register loads the pair that this character completes when the character
// leaves the input register.
// Reset clears the running coordinates, the partial value, the lat/lon phase and the pair error.
// A waiting result stalls the input only while the held character completes a pair; the
// stall lasts as long as out_stall holds that result. A pair takes at least two characters.
`default_nettype none
`include "encoded_polyline_decoder_top_macros.svh"

module encoded_polyline_decoder_top
    import epd_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [7:0]                char_code,
    input  logic                      restart,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic signed [COORD_W-1:0] latitude_e5,
    output logic signed [COORD_W-1:0] longitude_e5,
    output logic                      bad_input
);

    logic               pipe_valid_reg;
    logic [7:0]         pipe_char_reg;
    logic               pipe_restart_reg;
    epd_state_t         state_reg;
    epd_state_t         state_next;
    epd_result_t        step_res;
    logic               out_valid_reg;
    logic [COORD_W-1:0] out_lat_reg;
    logic [COORD_W-1:0] out_lon_reg;
    logic               out_bad_reg;
    logic               advance;
    logic               in_take;

    epd_step u_step (
        .state_q   (state_reg),
        .char_code (pipe_char_reg),
        .restart   (pipe_restart_reg),
        .state_d   (state_next),
        .result    (step_res)
    );

    // Hold the held character only when it completes a pair and the result slot is blocked.
    assign advance  = pipe_valid_reg && !(step_res.emit && out_valid_reg && out_stall);
    assign in_stall = pipe_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pipe_valid_reg <= 1'b0;
            state_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (in_take)
                pipe_valid_reg <= 1'b1;
            else if (advance)
                pipe_valid_reg <= 1'b0;

            if (advance)
                state_reg <= state_next;

            if (advance && step_res.emit)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            pipe_char_reg    <= char_code;
            pipe_restart_reg <= restart;
        end
        if (advance && step_res.emit)
        begin
            out_lat_reg <= step_res.lat;
            out_lon_reg <= step_res.lon;
            out_bad_reg <= step_res.bad;
        end
    end

    assign out_valid    = out_valid_reg;
    assign latitude_e5  = out_lat_reg;
    assign longitude_e5 = out_lon_reg;
    assign bad_input    = out_bad_reg;

    `EPD_ASSERT_NEVER(a_stall_needs_item, in_stall && !pipe_valid_reg)
    `EPD_ASSERT_NEVER(a_chunk_count_bound, state_reg.cnt > CHUNK_LIMIT)
    `EPD_ASSERT_SAME(a_emit_on_longitude, pipe_valid_reg && step_res.emit,
        state_reg.on_lon && !pipe_restart_reg)
    `EPD_ASSERT_NEXT(a_pair_loads_result, advance && step_res.emit,
        out_valid && !state_reg.on_lon && !state_reg.perr)

endmodule

`default_nettype wire

>>> rtl/core/epd_step.sv
// One character of decode: next decoder state and the optional coordinate pair.
// Depends on epd_pkg. Purely combinational.
`default_nettype none

module epd_step
    import epd_pkg::*;
(
    input  epd_state_t  state_q,
    input  logic [7:0]  char_code,
    input  logic        restart,
    output epd_state_t  state_d,
    output epd_result_t result
);

    epd_state_t         base;
    logic [7:0]         biased;
    logic [CHUNK_W-1:0] chunk;
    logic               last;
    logic               out_of_range;
    logic               room;
    logic [COORD_W-1:0] accum_new;
    logic [COORD_W-1:0] half;
    logic [COORD_W-1:0] delta;
    logic               perr_new;

    always_comb
    begin
        base = restart ? '0 : state_q;

        biased       = char_code - CHAR_BIAS;
        chunk        = biased[CHUNK_W-1:0];
        last         = char_code < CHAR_CONT;
        out_of_range = (char_code < CHAR_BIAS) || (char_code > CHAR_MAX);
        room         = base.cnt < CHUNK_LIMIT;

        // Bits shifted above the top of the word are dropped.
        accum_new = base.accum;
        if (room)
        begin
            accum_new = base.accum
                      | ({{(COORD_W-CHUNK_W){1'b0}}, chunk} << chunk_shift(base.cnt));
        end
        perr_new = base.perr | out_of_range | !room;

        half  = accum_new >> 1;
        delta = accum_new[0] ? ~half : half;

        state_d      = base;
        state_d.perr = perr_new;
        result       = '0;

        if (!last)
        begin
            state_d.accum = accum_new;
            state_d.cnt   = room ? base.cnt + 3'd1 : base.cnt;
        end
        else
        begin
            state_d.accum = '0;
            state_d.cnt   = '0;
            if (!base.on_lon)
            begin
                state_d.lat    = base.lat + delta;
                state_d.on_lon = 1'b1;
            end
            else
            begin
                state_d.lon    = base.lon + delta;
                state_d.on_lon = 1'b0;
                state_d.perr   = 1'b0;
                result.emit    = 1'b1;
                result.lat     = base.lat;
                result.lon     = base.lon + delta;
                result.bad     = perr_new;
            end
        end
    end

endmodule

`default_nettype wire

>>> test/encoded_polyline_decoder_top_test.sv
// Self-checking testbench for encoded_polyline_decoder_top: directed table, then random polylines.
// Coordinate pairs are predicted in the bench and checked field by field.
// Depends on epd_pkg and the decoder RTL only.
module encoded_polyline_decoder_top_test;
    import epd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic signed [COORD_W-1:0] lat;
        logic signed [COORD_W-1:0] lon;
        logic                      bad;
    } pair_t;

    typedef struct packed {
        logic [7:0] code;
        logic       rst;
    } char_item_t;

    // typed == 1: the pair this character completes is written in the row
    typedef struct packed {
        logic [7:0]                code;
        logic                      rst;
        logic                      typed;
        logic signed [COORD_W-1:0] lat;
        logic signed [COORD_W-1:0] lon;
        logic                      bad;
    } dir_row_t;

    localparam int NUM_DIR = 24;
    localparam int NUM_RANDOM = 1300;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      in_valid = 1'b0;
    logic                      in_stall;
    logic [7:0]                char_code = 8'd0;
    logic                      restart = 1'b0;
    logic                      out_valid;
    logic                      out_stall = 1'b0;
    logic signed [COORD_W-1:0] latitude_e5;
    logic signed [COORD_W-1:0] longitude_e5;
    logic                      bad_input;

    // decoder state mirror
    logic [COORD_W-1:0] value_acc;
    logic [CNT_W-1:0]   chunk_cnt;
    logic               lon_next;
    logic [COORD_W-1:0] lat_sum;
    logic [COORD_W-1:0] lon_sum;
    logic               pair_bad;

    pair_t      expected_pairs[$];
    char_item_t char_plan[$];
    int         err_count = 0;
    int         chars_sent = 0;
    int         pairs_seen = 0;
    int         bad_pairs_seen = 0;
    int         send_idle_pct = 0;
    int         stall_pct = 0;

    dir_row_t dir_rows [0:NUM_DIR-1] = '{
        '{8'd63,  1'b1, 1'b0, 32'sd0, 32'sd0, 1'b0},
        '{8'd63,  1'b0, 1'b1, 32'sd0, 32'sd0, 1'b0},
        '{8'd64,  1'b0, 1'b0, 32'sd0, 32'sd0, 1'b0},
        '{8'd62,  1'b0, 1'b1, -32'sd1, -32'sd16, 1'b1},
        '{8'd255, 1'b0, 1'b0, 32'sd0, 32'sd0, 1'b0},
        '{8'd0,   1'b0, 1'b0, 32'sd0, 32'sd0, 1'b0},
        '{8'd126, 1'b0, 1'b0, 32'sd0, 32'sd0, 1'b0},
        '{8'd94,  1'b0, 1'b0, 32'sd0, 32'sd0, 1'b0},
        '{8'd126, 1'b1, 1'b0, 32'sd0, 32'sd0, 1'b0},
        '{8'd126, 1'b0, 1'b0, 32'sd0, 32'sd0, 1'b0},
        '{8'd126, 1'b0, 1'b0, 32'sd0, 32'sd0, 1'b0},
        '{8'd126, 1'b0, 1'b0, 32'sd0, 32'sd0, 1'b0},
        '{8'd126, 1'b0, 1'b0, 32'sd0, 32'sd0, 1'b0},
        '{8'd126, 1'b0, 1'b0, 32'sd0, 32'sd0, 1'b0},
        '{8'd126, 1'b0, 1'b0, 32'sd0, 32'sd0, 1'b0},
        '{8'd126, 1'b0, 1'b0, 32'sd0, 32'sd0, 1'b0},
        '{8'd94,  1'b0, 1'b0, 32'sd0, 32'sd0, 1'b0},
        '{8'd125, 1'b0, 1'b0, 32'sd0, 32'sd0, 1'b0},
        '{8'd126, 1'b0, 1'b0, 32'sd0, 32'sd0, 1'b0},
        '{8'd126, 1'b0, 1'b0, 32'sd0, 32'sd0, 1'b0},
        '{8'd126, 1'b0, 1'b0, 32'sd0, 32'sd0, 1'b0},
        '{8'd126, 1'b0, 1'b0, 32'sd0, 32'sd0, 1'b0},
        '{8'd126, 1'b0, 1'b0, 32'sd0, 32'sd0, 1'b0},
        '{8'd94,  1'b0, 1'b1, 32'sh8000_0000, 32'sh7fff_ffff, 1'b1}
    };

    encoded_polyline_decoder_top u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .char_code    (char_code),
        .restart      (restart),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .latitude_e5  (latitude_e5),
        .longitude_e5 (longitude_e5),
        .bad_input    (bad_input)
    );

    always #1 clk = ~clk;

    initial
    begin
        #200_000;
        $display("*** FAILED ***");
        $finish;
    end

    // Advance the mirrored decoder by one character; returns 1 when a pair completes.
    function automatic bit decode_char(input logic [7:0] code, input logic rst,
                                       output pair_t pair);
        logic [4:0]         chunk;
        logic [63:0]        placed;
        logic [COORD_W-1:0] half;
        logic [COORD_W-1:0] delta;
        pair = '0;
        if (rst)
        begin
            value_acc = '0;
            chunk_cnt = '0;
            lon_next  = 1'b0;
            lat_sum   = '0;
            lon_sum   = '0;
            pair_bad  = 1'b0;
        end
        if (code < CHAR_BIAS || code > CHAR_MAX)
            pair_bad = 1'b1;
        chunk = 5'(code - CHAR_BIAS);
        if (chunk_cnt < CHUNK_LIMIT)
        begin
            // bits above 31 fall off silently
            placed    = 64'(chunk) << (5 * chunk_cnt);
            value_acc = value_acc | placed[COORD_W-1:0];
            chunk_cnt = chunk_cnt + 3'd1;
        end
        else
            pair_bad = 1'b1;
        if (code >= CHAR_CONT)
            return 1'b0;
        half      = value_acc >> 1;
        delta     = value_acc[0] ? ~half : half;
        value_acc = '0;
        chunk_cnt = '0;
        if (!lon_next)
        begin
            lat_sum  = lat_sum + delta;
            lon_next = 1'b1;
            return 1'b0;
        end
        lon_sum   = lon_sum + delta;
        lon_next  = 1'b0;
        pair.lat  = lat_sum;
        pair.lon  = lon_sum;
        pair.bad  = pair_bad;
        pair_bad  = 1'b0;
        return 1'b1;
    endfunction

    // Encode one signed delta as polyline characters; drop the last one if broken and there are several.
    function automatic void plan_value(input logic signed [COORD_W-1:0] d, input bit broken,
                                       input logic rst);
        logic [COORD_W-1:0] v;
        logic [5:0]         c;
        char_item_t         item;
        char_item_t         items[$];
        v = {d[COORD_W-2:0], 1'b0} ^ {COORD_W{d[COORD_W-1]}};
        do
        begin
            c = {1'b0, v[4:0]};
            v = v >> 5;
            if (v != 0)
                c[5] = 1'b1;
            item = '{code: 8'(c) + CHAR_BIAS, rst: 1'b0};
            items.insert(items.size(), item);
        end
        while (v != 0);
        items[0].rst = rst;
        if (broken && items.size() > 1)
            void'(items.pop_back());
        foreach (items[k])
            char_plan.insert(char_plan.size(), items[k]);
    endfunction

    function automatic logic signed [COORD_W-1:0] random_delta();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: return $urandom_range(0, 2000) - 1000;
            6, 7:             return $urandom_range(0, 1 << 20) - (1 << 19);
            default:          return $urandom;
        endcase
    endfunction

    function automatic void build_plan();
        int         n_values;
        bit         first;
        char_item_t noise;
        while (char_plan.size() < NUM_RANDOM)
        begin
            n_values = 2 * $urandom_range(1, 8);
            first = 1'b1;
            for (int v = 0; v < n_values; v++)
            begin
                // noise: any byte, occasionally with a stray restart
                if ($urandom_range(0, 99) < 8)
                begin
                    noise = '{code: 8'($urandom), rst: ($urandom_range(0, 7) == 0)};
                    char_plan.insert(char_plan.size(), noise);
                end
                plan_value(random_delta(), $urandom_range(0, 99) < 5, first);
                first = 1'b0;
            end
        end
    endfunction

    // Present one transaction and hold it until accepted.
    task automatic put_char(input logic [7:0] code, input logic rst, input bit typed,
                            input pair_t typed_pair);
        pair_t pair;
        bit    done;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid  <= 1'b0;
            char_code <= 8'($urandom);
            restart   <= 1'($urandom);
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        char_code <= code;
        restart   <= rst;
        do
            @(posedge clk);
        while (in_stall);
        chars_sent++;
        done = decode_char(code, rst, pair);
        if (typed)
            expected_pairs.insert(expected_pairs.size(), typed_pair);
        else if (done)
            expected_pairs.insert(expected_pairs.size(), pair);
        @(negedge clk);
    endtask

    always @(negedge clk)
        out_stall <= ($urandom_range(0, 99) < stall_pct);

    always @(posedge clk)
    begin
        pair_t exp_pair;
        if (rst_n && out_valid && !out_stall)
        begin
            pairs_seen++;
            if (bad_input)
                bad_pairs_seen++;
            if (expected_pairs.size() == 0)
            begin
                $error("coordinate pair with none expected: lat %0d lon %0d bad %0b",
                       latitude_e5, longitude_e5, bad_input);
                err_count++;
            end
            else
            begin
                exp_pair = expected_pairs.pop_front();
                if (latitude_e5 !== exp_pair.lat)
                begin
                    $error("latitude_e5: expected %0d, got %0d", exp_pair.lat, latitude_e5);
                    err_count++;
                end
                if (longitude_e5 !== exp_pair.lon)
                begin
                    $error("longitude_e5: expected %0d, got %0d", exp_pair.lon, longitude_e5);
                    err_count++;
                end
                if (bad_input !== exp_pair.bad)
                begin
                    $error("bad_input: expected %0b, got %0b", exp_pair.bad, bad_input);
                    err_count++;
                end
            end
        end
    end

    initial
    begin
        pair_t typed_pair;
        int    phase;
        value_acc = '0;
        chunk_cnt = '0;
        lon_next  = 1'b0;
        lat_sum   = '0;
        lon_sum   = '0;
        pair_bad  = 1'b0;
        build_plan();

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (dir_rows[i])
        begin
            typed_pair = '{lat: dir_rows[i].lat, lon: dir_rows[i].lon, bad: dir_rows[i].bad};
            put_char(dir_rows[i].code, dir_rows[i].rst, dir_rows[i].typed, typed_pair);
        end

        // four idling phases across the random part
        foreach (char_plan[i])
        begin
            phase = i * 4 / char_plan.size();
            case (phase)
                0:       begin send_idle_pct = 0;  stall_pct = 0;  end
                1:       begin send_idle_pct = 72; stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  stall_pct = 72; end
                default: begin send_idle_pct = 6;  stall_pct = 6;  end
            endcase
            put_char(char_plan[i].code, char_plan[i].rst, 1'b0, '0);
        end
        in_valid <= 1'b0;

        while (expected_pairs.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("Sent %0d characters (directed and random polylines with noise),",
                 chars_sent);
        $display("checked %0d coordinate pairs, %0d of them flagged bad.",
                 pairs_seen, bad_pairs_seen);
        if (err_count == 0 && expected_pairs.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

>>> encoded_polyline_decoder_top.f
+incdir+rtl/core
rtl/core/epd_pkg.sv
rtl/core/epd_step.sv
rtl/core/encoded_polyline_decoder_top.sv
test/encoded_polyline_decoder_top_test.sv
